[src/md5_pkg.sv]
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_DONE
  } md5_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } md5_rctl_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS = 6'h3F;
  localparam logic [5:0] LAST_RND = 6'd63;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;
      6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;
      6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;
      6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;
      6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;
      6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;
      6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;
      6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;
      6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;
      6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;
      6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;
      6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;
      6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;
      6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;
      6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;
      6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;
      6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;
      6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;
      6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;
      6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;
      6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;
      6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;
      6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;
      6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;
      6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] m;
    lo = r[3:0];
    case (r[5:4])
      2'd0: m = lo;
      2'd1: m = 4'((lo << 2) + lo + 4'd1);
      2'd2: m = 4'((lo << 1) + lo + 4'd5);
      2'd3: m = 4'((lo << 3) - lo);
      default: m = lo;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (ph)
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

[src/md5_round.sv]
module md5_round (
  input  logic                   clk,
  input  md5_pkg::md5_rctl_t     ctl,
  input  logic [3:0][31:0]       chain_i,
  input  logic [31:0]            w_i,
  output logic [3:0][31:0]       st_o
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] new_b;

  always_comb begin
    sum = a_r + md5_pkg::round_fn(ctl.rnd[5:4], b_r, c_r, d_r) + w_i
        + md5_pkg::round_const(ctl.rnd);
    dbl = {sum, sum} << md5_pkg::rot_amt(ctl.rnd);
    new_b = dbl[63:32] + b_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= chain_i[0];
      b_r <= chain_i[1];
      c_r <= chain_i[2];
      d_r <= chain_i[3];
    end else if (ctl.step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= new_b;
    end
  end

  assign st_o = {d_r, c_r, b_r, a_r};

endmodule

[src/md5_message_digest_core.sv]
// MD5 digest engine taking one message byte per transaction. A byte that does not
// complete a 64-byte block is taken without raising in_stall. The byte that
// completes a block starts a compression (one operand fetch, 64 rounds through a
// single shared round unit, one chaining add) during which in_stall is high. A
// transaction with last set pads the message: each remaining block word is written
// in turn, then one compression follows, or two when fewer than nine bytes of room
// remain. The four digest words A to D then leave on the out channel from an output
// buffer; a new message is accepted while they are still being drained, but its end
// waits until the buffer is empty.
module md5_message_digest_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::md5_in_t   in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::md5_out_t  out_payload
);

  md5_pkg::md5_state_t state_r, state_nxt;
  logic [5:0]          rnd_r, rnd_nxt;
  logic [3:0]          widx_r, widx_nxt;
  logic                fin_r, fin_nxt;
  logic                padded_r, padded_nxt;
  logic                second_r, second_nxt;
  logic [60:0]         count_r, count_nxt;
  logic [31:0]         asm_r, asm_nxt;
  logic [3:0][31:0]    chain_r, chain_nxt;
  logic [3:0][31:0]    dig_r, dig_nxt;
  logic                out_busy_r, out_busy_nxt;
  logic [1:0]          out_idx_r, out_idx_nxt;

  logic [31:0] wmem [16];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;

  md5_pkg::md5_rctl_t rctl;
  logic [3:0][31:0]   st;

  logic        in_accept;
  logic        out_accept;
  logic [4:0]  lane_sh;
  logic [31:0] asm_ins;
  logic [31:0] pad_first;
  logic        len_here;
  logic [31:0] pad_word;
  logic [60:0] count_inc;

  md5_round u_round (
    .clk     (clk),
    .ctl     (rctl),
    .chain_i (chain_r),
    .w_i     (rdata_r),
    .st_o    (st)
  );

  assign in_stall   = (state_r != md5_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = out_busy_r;
  assign out_accept = out_busy_r && !out_stall;

  assign out_payload.digest_word = dig_r[out_idx_r];
  assign out_payload.word_index  = out_idx_r;
  assign out_payload.last_word   = (out_idx_r == 2'd3);

  assign lane_sh   = {count_r[1:0], 3'b000};
  assign asm_ins   = (asm_r & ~(32'hFF << lane_sh)) | ({24'd0, in_payload.data_byte} << lane_sh);
  assign pad_first = (asm_r & ((32'h1 << lane_sh) - 32'h1))
                   | ({24'd0, md5_pkg::PAD_BYTE} << lane_sh);
  assign len_here  = second_r || (count_r[5:3] != 3'b111);
  assign count_inc = count_r + 61'd1;

  always_comb begin
    if (!second_r && (widx_r == count_r[5:2])) begin
      pad_word = pad_first;
    end else if (len_here && (widx_r == 4'd14)) begin
      pad_word = {count_r[28:0], 3'b000};
    end else if (len_here && (widx_r == 4'd15)) begin
      pad_word = count_r[60:29];
    end else begin
      pad_word = 32'd0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    widx_nxt     = widx_r;
    fin_nxt      = fin_r;
    padded_nxt   = padded_r;
    second_nxt   = second_r;
    count_nxt    = count_r;
    asm_nxt      = asm_r;
    chain_nxt    = chain_r;
    dig_nxt      = dig_r;
    out_busy_nxt = out_busy_r;
    out_idx_nxt  = out_idx_r;
    mem_we       = 1'b0;
    mem_waddr    = count_r[5:2];
    mem_wdata    = asm_ins;
    mem_raddr    = md5_pkg::msg_idx(6'd0);
    rctl.load    = 1'b0;
    rctl.step    = 1'b0;
    rctl.rnd     = rnd_r;

    if (out_accept) begin
      out_idx_nxt = out_idx_r + 2'd1;
      if (out_idx_r == 2'd3) begin
        out_busy_nxt = 1'b0;
      end
    end

    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_payload.byte_valid) begin
            asm_nxt   = asm_ins;
            count_nxt = count_inc;
            mem_we    = (count_r[1:0] == 2'd3);
          end
          if (in_payload.last) begin
            fin_nxt = 1'b1;
          end
          if (in_payload.byte_valid && (count_r[5:0] == md5_pkg::LAST_POS)) begin
            state_nxt = md5_pkg::ST_LOAD;
          end else if (in_payload.last) begin
            state_nxt  = md5_pkg::ST_PAD;
            padded_nxt = 1'b1;
            second_nxt = 1'b0;
            widx_nxt   = count_nxt[5:2];
          end
        end
      end
      md5_pkg::ST_LOAD: begin
        mem_raddr = md5_pkg::msg_idx(6'd0);
        rctl.load = 1'b1;
        rnd_nxt   = 6'd0;
        state_nxt = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        rctl.step = 1'b1;
        mem_raddr = md5_pkg::msg_idx(rnd_r + 6'd1);
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == md5_pkg::LAST_RND) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + st[i];
        end
        if (!fin_r) begin
          state_nxt = md5_pkg::ST_IDLE;
        end else if (!padded_r) begin
          state_nxt  = md5_pkg::ST_PAD;
          padded_nxt = 1'b1;
          widx_nxt   = count_r[5:2];
        end else if (!second_r && !len_here) begin
          state_nxt  = md5_pkg::ST_PAD;
          second_nxt = 1'b1;
          widx_nxt   = 4'd0;
        end else begin
          state_nxt = md5_pkg::ST_DONE;
        end
      end
      md5_pkg::ST_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = widx_r;
        mem_wdata = pad_word;
        widx_nxt  = widx_r + 4'd1;
        if (widx_r == 4'd15) begin
          state_nxt = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_DONE: begin
        if (!out_busy_r) begin
          dig_nxt      = chain_r;
          chain_nxt    = {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
          count_nxt    = 61'd0;
          fin_nxt      = 1'b0;
          padded_nxt   = 1'b0;
          second_nxt   = 1'b0;
          out_busy_nxt = 1'b1;
          out_idx_nxt  = 2'd0;
          state_nxt    = md5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= md5_pkg::ST_IDLE;
      rnd_r      <= 6'd0;
      widx_r     <= 4'd0;
      fin_r      <= 1'b0;
      padded_r   <= 1'b0;
      second_r   <= 1'b0;
      count_r    <= 61'd0;
      chain_r    <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
      out_busy_r <= 1'b0;
      out_idx_r  <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      widx_r     <= widx_nxt;
      fin_r      <= fin_nxt;
      padded_r   <= padded_nxt;
      second_r   <= second_nxt;
      count_r    <= count_nxt;
      chain_r    <= chain_nxt;
      out_busy_r <= out_busy_nxt;
      out_idx_r  <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
    dig_r <= dig_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= wmem[mem_raddr];
  end

`ifndef ASSERT_OFF
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_ROUND) && (rnd_r == md5_pkg::LAST_RND)
      |=> (state_r == md5_pkg::ST_ADD))
    else $error("compression did not end after the last round");

  a_pad_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_PAD) |-> (fin_r && padded_r))
    else $error("padding without a finished message");

  a_digest_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_DONE) && !out_busy_r
      |=> out_valid && (out_idx_r == 2'd0) && (count_r == 61'd0))
    else $error("digest not loaded into output buffer");

  a_last_word_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.last_word && !out_stall && (state_r != md5_pkg::ST_DONE)
      |=> !out_valid)
    else $error("output still valid after final digest word");
`endif

endmodule
